### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, constants and helpers shared by the I2C master register transfer unit.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam logic [7:0] MAX_BYTES         = 8'd255;
	localparam logic [7:0] BYTE_MSB          = 8'h80;
	localparam logic [7:0] PHASE_TICKS_RESET = 8'd5;
	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	typedef enum logic [0:0] {
		REG_PHASE_TICKS = 1'b0,
		REG_ACK_TIMEOUT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_START    = 4'd1,
		PH_ADDR_W   = 4'd2,
		PH_ACK_AW   = 4'd3,
		PH_REG      = 4'd4,
		PH_ACK_REG  = 4'd5,
		PH_DATA     = 4'd6,
		PH_ACK_DATA = 4'd7,
		PH_RSTART   = 4'd8,
		PH_ADDR_R   = 4'd9,
		PH_ACK_AR   = 4'd10,
		PH_READ     = 4'd11,
		PH_MACK     = 4'd12,
		PH_STOP     = 4'd13
	} phase_t;

	typedef struct packed {
		logic [1:0] command;
		logic [6:0] device_address;
		logic [7:0] register_address;
		logic [7:0] byte_count;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       write_taken;
		logic       read_valid;
		logic [7:0] read_data;
		logic       last_byte;
		logic       done_res;
		logic       nack_error;
	} result_t;

	typedef struct packed {
		logic       start;
		logic       is_read;
		logic [6:0] device_address;
		logic [7:0] register_address;
		logic [7:0] byte_count;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic taken;
		logic valid;
		logic last;
		logic done;
	} event_t;

	function automatic logic is_send(input phase_t p);
		return (p == PH_ADDR_W) || (p == PH_REG) || (p == PH_DATA) || (p == PH_ADDR_R);
	endfunction

	function automatic logic is_ack(input phase_t p);
		return (p == PH_ACK_AW) || (p == PH_ACK_REG) || (p == PH_ACK_DATA) ||
			(p == PH_ACK_AR);
	endfunction

	function automatic logic [1:0] last_quarter(input phase_t p);
		return ((p == PH_START) || (p == PH_RSTART) || (p == PH_STOP)) ? 2'd2 : 2'd3;
	endfunction

endpackage

### rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Input queue: accepts ticks, decodes the command and saturates the count.
// ----------------------------------------------------------------------------
module i2cm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  i2cm_pkg::item_t item,
	output logic            tick_valid,
	output i2cm_pkg::tick_t tick,
	input  logic            tick_take
);
	import i2cm_pkg::*;

	tick_t      entry_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	tick_t      cls;
	logic       do_push;

	always_comb begin
		cls                  = '0;
		cls.start            = (item.command == CMD_WRITE) || (item.command == CMD_READ);
		cls.is_read          = (item.command == CMD_READ);
		cls.device_address   = item.device_address;
		cls.register_address = item.register_address;
		cls.byte_count       = (item.byte_count > MAX_BYTES) ? MAX_BYTES : item.byte_count;
		cls.write_data       = item.write_data;
		cls.sda_in           = item.sda_in;
	end

	assign full       = (count_q == 2'(QDEPTH));
	assign do_push    = push && !full;
	assign tick_valid = (count_q != 2'd0);
	assign tick       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (tick_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(tick_take);
		end
	end

endmodule

### rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: advances the line phases one tick at a time.
// ----------------------------------------------------------------------------
module i2cm_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        phase_ticks,
	input  logic [7:0]        ack_timeout,
	input  logic              tick_valid,
	input  i2cm_pkg::tick_t   tick,
	output logic              tick_take,
	input  logic              res_full,
	output logic              res_push,
	output i2cm_pkg::result_t res
);
	import i2cm_pkg::*;

	phase_t     phase_q, n_phase;
	logic [1:0] quarter_q, n_quarter;
	logic [7:0] timer_q, n_timer;
	logic [2:0] bit_q, n_bit;
	logic [7:0] bytes_q, n_bytes;
	logic [7:0] shift_q, n_shift;
	logic [7:0] ackw_q, n_ackw;
	logic [6:0] taddr_q, n_taddr;
	logic [7:0] regnum_q, n_regnum;
	logic       is_read_q, n_is_read;
	logic       failed_q, n_failed;
	event_t     ev;
	logic       enter;
	phase_t     enter_ph;
	logic [7:0] pt;
	logic [7:0] at;
	logic [7:0] timer_inc;
	logic [7:0] ackw_inc;
	logic       scl_n;
	logic       sda_n;

	assign pt        = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
	assign at        = (ack_timeout == 8'd0) ? 8'd1 : ack_timeout;
	assign tick_take = tick_valid && !res_full;
	assign res_push  = tick_take;
	assign timer_inc = timer_q + 8'd1;
	assign ackw_inc  = ackw_q + 8'd1;

	always_comb begin
		n_phase   = phase_q;
		n_quarter = quarter_q;
		n_timer   = timer_q;
		n_bit     = bit_q;
		n_bytes   = bytes_q;
		n_shift   = shift_q;
		n_ackw    = ackw_q;
		n_taddr   = taddr_q;
		n_regnum  = regnum_q;
		n_is_read = is_read_q;
		n_failed  = failed_q;
		ev        = '0;
		enter     = 1'b0;
		enter_ph  = PH_IDLE;
		if (phase_q == PH_IDLE) begin
			if (tick.start) begin
				n_taddr   = tick.device_address;
				n_regnum  = tick.register_address;
				n_bytes   = tick.byte_count;
				n_is_read = tick.is_read;
				n_failed  = 1'b0;
				enter     = 1'b1;
				enter_ph  = PH_START;
			end
		end else if (is_ack(phase_q) && (quarter_q == 2'd3)) begin
			if (!tick.sda_in) begin
				enter = 1'b1;
				priority case (phase_q)
					PH_ACK_AW: begin
						enter_ph = PH_REG;
						n_shift  = regnum_q;
					end
					PH_ACK_REG: begin
						if (bytes_q == 8'd0) begin
							enter_ph = PH_STOP;
						end else if (is_read_q) begin
							enter_ph = PH_RSTART;
						end else begin
							enter_ph = PH_DATA;
							n_shift  = tick.write_data;
							n_bytes  = bytes_q - 8'd1;
							ev.taken = 1'b1;
						end
					end
					PH_ACK_DATA: begin
						if (bytes_q == 8'd0) begin
							enter_ph = PH_STOP;
						end else begin
							enter_ph = PH_DATA;
							n_shift  = tick.write_data;
							n_bytes  = bytes_q - 8'd1;
							ev.taken = 1'b1;
						end
					end
					default: begin
						enter_ph = PH_READ;
						n_shift  = 8'd0;
					end
				endcase
			end else begin
				n_ackw = ackw_inc;
				if (ackw_inc >= at) begin
					n_failed = 1'b1;
					enter    = 1'b1;
					enter_ph = PH_STOP;
				end
			end
		end else begin
			n_timer = timer_inc;
			if (timer_inc >= pt) begin
				n_timer = 8'd0;
				if (quarter_q < last_quarter(phase_q)) begin
					n_quarter = quarter_q + 2'd1;
				end else if (phase_q == PH_START) begin
					enter    = 1'b1;
					enter_ph = PH_ADDR_W;
					n_shift  = {taddr_q, 1'b0};
				end else if (phase_q == PH_RSTART) begin
					enter    = 1'b1;
					enter_ph = PH_ADDR_R;
					n_shift  = {taddr_q, 1'b1};
				end else if (is_send(phase_q)) begin
					if (bit_q == 3'd7) begin
						enter    = 1'b1;
						enter_ph = phase_t'(phase_q + 4'd1);
					end else begin
						n_bit     = bit_q + 3'd1;
						n_shift   = {shift_q[6:0], 1'b0};
						n_quarter = 2'd0;
					end
				end else if (phase_q == PH_READ) begin
					n_shift = {shift_q[6:0], tick.sda_in};
					if (bit_q == 3'd7) begin
						n_bytes  = bytes_q - 8'd1;
						ev.valid = 1'b1;
						ev.last  = (bytes_q == 8'd1);
						enter    = 1'b1;
						enter_ph = PH_MACK;
					end else begin
						n_bit     = bit_q + 3'd1;
						n_quarter = 2'd0;
					end
				end else if (phase_q == PH_MACK) begin
					enter = 1'b1;
					if (bytes_q == 8'd0) begin
						enter_ph = PH_STOP;
					end else begin
						enter_ph = PH_READ;
						n_shift  = 8'd0;
					end
				end else begin
					enter    = 1'b1;
					enter_ph = PH_IDLE;
					ev.done  = 1'b1;
				end
			end
		end
		if (enter) begin
			n_phase   = enter_ph;
			n_quarter = 2'd0;
			n_timer   = 8'd0;
			n_bit     = 3'd0;
			n_ackw    = 8'd0;
		end
	end

	always_comb begin
		scl_n = (n_quarter >= 2'd2);
		sda_n = 1'b1;
		if (n_phase == PH_IDLE) begin
			scl_n = 1'b1;
		end else if ((n_phase == PH_START) || (n_phase == PH_RSTART)) begin
			scl_n = (n_quarter >= 2'd1);
			sda_n = (n_quarter < 2'd2);
		end else if (n_phase == PH_STOP) begin
			scl_n = (n_quarter >= 2'd1);
			sda_n = (n_quarter >= 2'd2);
		end else if (is_send(n_phase)) begin
			sda_n = |(n_shift & BYTE_MSB);
		end else if (n_phase == PH_MACK) begin
			sda_n = (n_bytes == 8'd0);
		end
		res             = '0;
		res.scl_out     = scl_n;
		res.sda_out     = sda_n;
		res.busy_res    = (n_phase != PH_IDLE);
		res.write_taken = ev.taken;
		res.read_valid  = ev.valid;
		res.read_data   = ev.valid ? n_shift : 8'd0;
		res.last_byte   = ev.valid && ev.last;
		res.done_res    = ev.done;
		res.nack_error  = ev.done && n_failed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			quarter_q <= 2'd0;
			timer_q   <= 8'd0;
			bit_q     <= 3'd0;
			bytes_q   <= 8'd0;
			shift_q   <= 8'd0;
			ackw_q    <= 8'd0;
			taddr_q   <= 7'd0;
			regnum_q  <= 8'd0;
			is_read_q <= 1'b0;
			failed_q  <= 1'b0;
		end else if (tick_take) begin
			phase_q   <= n_phase;
			quarter_q <= n_quarter;
			timer_q   <= n_timer;
			bit_q     <= n_bit;
			bytes_q   <= n_bytes;
			shift_q   <= n_shift;
			ackw_q    <= n_ackw;
			taddr_q   <= n_taddr;
			regnum_q  <= n_regnum;
			is_read_q <= n_is_read;
			failed_q  <= n_failed;
		end
	end

`ifndef SYNTHESIS
	a_taken_enters_data: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_take && res.write_taken) |=> (phase_q == PH_DATA))
		else $error("write byte taken without entering data phase");
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_take && res.done_res) |=> (phase_q == PH_IDLE))
		else $error("done reported while still busy");
	a_nack_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.nack_error |-> res.done_res)
		else $error("error flag without done");
	a_short_phase_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_START) || (phase_q == PH_RSTART) || (phase_q == PH_STOP))
		|-> (quarter_q != 2'd3))
		else $error("quarter overrun in start or stop");
	a_read_only_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_take && res.read_valid) |-> (phase_q == PH_READ) && is_read_q)
		else $error("read byte outside read phase");
`endif

endmodule

### rtl/i2cm_res_q.sv
// ----------------------------------------------------------------------------
// i2cm_res_q
// Result queue: holds finished results until the receiver pops them.
// ----------------------------------------------------------------------------
module i2cm_res_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_push,
	input  i2cm_pkg::result_t res,
	output logic              res_full,
	input  logic              pop,
	output logic              empty,
	output i2cm_pkg::result_t result
);
	import i2cm_pkg::*;

	result_t    entry_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign res_full = (count_q == 2'(QDEPTH));
	assign empty    = (count_q == 2'd0);
	assign do_pop   = pop && !empty;
	assign result   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			entry_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(res_push) - 2'(do_pop);
		end
	end

endmodule

### rtl/i2c_master_register_transfer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_register_transfer_unit
// I2C master for register writes and reads, stepped one bus tick per item.
// ----------------------------------------------------------------------------
// Input: push an item (command, address, register, count, write byte, SDA
// sample) each bus tick while full is low. Output: one result per item
// (SCL/SDA drive, busy, write_taken, read byte, done, error), popped while
// empty is low, in item order.
// An item goes into the input queue, then its result into the result
// queue, before it can be popped. Throughput: one item per cycle; the
// sequencer advances one tick per cycle while the result queue has room.
// Both sides have two-entry queues, so a stalled receiver first fills
// the result queue, then the input queue, and then full rises; nothing
// is dropped.
// Reset clears both queues and returns the sequencer to idle with both
// lines released; phase_ticks resets to 5 and ack_timeout to 250.
// Registers on the APB port: phase_ticks at 0x0, ack_timeout at 0x4.
// Write them only while the unit is idle.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  i2cm_pkg::item_t   item,
	input  logic              pop,
	output logic              empty,
	output i2cm_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import i2cm_pkg::*;

	logic [7:0] phase_ticks_q;
	logic [7:0] ack_timeout_q;
	logic       cfg_wr;
	reg_idx_t   cfg_idx;
	logic       tick_valid;
	tick_t      tick;
	logic       tick_take;
	logic       res_full;
	logic       res_push;
	result_t    res;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
			ack_timeout_q <= ACK_TIMEOUT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PHASE_TICKS: phase_ticks_q <= pwdata[7:0];
				REG_ACK_TIMEOUT: ack_timeout_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PHASE_TICKS: prdata = {24'd0, phase_ticks_q};
			REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_q};
			default:         prdata = 32'd0;
		endcase
	end

	i2cm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.tick_valid (tick_valid),
		.tick       (tick),
		.tick_take  (tick_take)
	);

	i2cm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_ticks (phase_ticks_q),
		.ack_timeout (ack_timeout_q),
		.tick_valid  (tick_valid),
		.tick        (tick),
		.tick_take   (tick_take),
		.res_full    (res_full),
		.res_push    (res_push),
		.res         (res)
	);

	i2cm_res_q u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule
